// File: design/wma_pkg.sv
// Shared types and constants for the windowed moving average block.
package wma_pkg;

	localparam int SAMPLE_W          = 16;
	localparam int WIN_W             = 5;
	localparam int USED_W            = 5;
	localparam int HISTORY_DEPTH_DEF = 16;
	localparam int ACC_W             = SAMPLE_W + WIN_W;
	localparam int MAG_W             = ACC_W - 1;
	localparam int S_TDATA_W         = 16;
	localparam int M_TDATA_W         = 24;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_ROUND,
		ST_DIV,
		ST_DONE
	} wma_state_t;

	typedef struct packed {
		logic push;
		logic rd_en;
	} ring_ctrl_t;

endpackage

// File: design/windowed_moving_average.sv
// Top level of the windowed moving average: sequencer, accumulator, output register.
//
// Each input word on s_* carries one signed 16-bit sample. It is written
// into a ring of HISTORY_DEPTH entries; then the newest n samples are
// averaged, n = min(max(window, 1), samples held), and the mean is rounded
// half away from zero. One output word on m_* carries the average and n.
// The user writes the window on cfg_* (always ready) only while the block is
// idle; the block itself does not enforce this. The window resets to 10.
// An item passes through the states in order: ST_IDLE takes the word,
// ST_SUM walks the ring through its single registered read port and adds
// the last word, ST_ROUND rounds, ST_DIV runs the bit-serial divider (20
// steps and the done flag) and ST_DONE loads the output register, which
// raises m_tvalid. The load step holds while the previous word still waits.
// s_tready is high only while the sequencer is idle. The finished word sits
// in the output register, so the next sample is taken while m_tvalid is
// still waiting; a second result is held until the first one leaves.
// Reset empties the ring (fill count zero), clears both valid flags and
// restores the default window.
module windowed_moving_average #(
	parameter int HISTORY_DEPTH = wma_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wma_pkg::WIN_W-1:0]       cfg_data,     // window_samples
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wma_pkg::S_TDATA_W-1:0]   s_tdata,      // [15:0] sample
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wma_pkg::M_TDATA_W-1:0]   m_tdata       // [15:0] average, [20:16] samples_used
);
	import wma_pkg::*;

	localparam int FW    = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W = (FW > WIN_W) ? FW : WIN_W;
	localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_DEPTH);

	wma_state_t state_q, state_d;

	logic [WIN_W-1:0]        window_q;
	logic [USED_W-1:0]       use_q;
	logic [USED_W-1:0]       issue_q;
	logic                    rd_vld_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    neg_q;
	logic                    out_valid_q;
	logic [SAMPLE_W-1:0]     avg_q;
	logic [USED_W-1:0]       used_q;

	ring_ctrl_t              ring_ctrl;
	logic [SAMPLE_W-1:0]     rd_data;
	logic [FW-1:0]           fill;
	logic [FW-1:0]           fill_next;
	logic [WIN_W-1:0]        win_eff;
	logic [USED_W-1:0]       use_d;
	logic                    accept;
	logic                    out_load;
	logic                    div_start;
	logic                    div_done;
	logic signed [ACC_W-1:0] adj;
	logic [MAG_W-1:0]        mag;
	logic [MAG_W-1:0]        quotient;
	logic [SAMPLE_W-1:0]     q16;

	wma_ring #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.FW           (FW)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ring_ctrl),
		.wr_data(s_tdata[SAMPLE_W-1:0]),
		.rd_data(rd_data),
		.fill   (fill)
	);

	wma_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mag),
		.divisor (use_q),
		.done    (div_done),
		.quotient(quotient)
	);

	// count of samples for the item being accepted
	always_comb begin
		win_eff   = (window_q == '0) ? WIN_W'(1) : window_q;
		fill_next = (fill == FILL_MAX) ? fill : fill + FW'(1);
		if (CMP_W'(win_eff) <= CMP_W'(fill_next)) begin
			use_d = win_eff;
		end else begin
			use_d = USED_W'(fill_next);
		end
	end

	// round half away from zero, then divide the magnitude
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			adj = acc_q - ACC_W'(use_q >> 1);
			mag = MAG_W'(-adj);
		end else begin
			adj = acc_q + ACC_W'(use_q >> 1);
			mag = MAG_W'(adj);
		end
		q16 = quotient[SAMPLE_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (issue_q == '0 && !rd_vld_q) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		ring_ctrl.push  = 1'b0;
		ring_ctrl.rd_en = 1'b0;
		div_start       = 1'b0;
		out_load        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready       = 1'b1;
				ring_ctrl.push = s_tvalid;
			end
			ST_SUM:   ring_ctrl.rd_en = (issue_q != '0);
			ST_ROUND: div_start = 1'b1;
			ST_DIV:   ;
			ST_DONE:  out_load = !out_valid_q || m_tready;
			default:  ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WIN_RESET;
			issue_q     <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= ring_ctrl.rd_en;
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			if (accept) begin
				issue_q <= use_d;
			end else if (ring_ctrl.rd_en) begin
				issue_q <= issue_q - USED_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_q <= use_d;
			acc_q <= '0;
		end else if (rd_vld_q) begin
			acc_q <= acc_q + ACC_W'($signed(rd_data));
		end
		if (div_start) begin
			neg_q <= acc_q[ACC_W-1];
		end
		if (out_load) begin
			avg_q  <= neg_q ? -q16 : q16;
			used_q <= use_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(M_TDATA_W - SAMPLE_W - USED_W){1'b0}}, used_q, avg_q};

endmodule

// File: design/wma_ring.sv
// Sample history ring: memory, write and read pointers, fill count.
module wma_ring #(
	parameter int HISTORY_DEPTH = wma_pkg::HISTORY_DEPTH_DEF,
	parameter int FW            = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wma_pkg::ring_ctrl_t           ctrl,
	input  logic [wma_pkg::SAMPLE_W-1:0]  wr_data,
	output logic [wma_pkg::SAMPLE_W-1:0]  rd_data,
	output logic [FW-1:0]                 fill
);
	import wma_pkg::*;

	localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [PW-1:0] PTR_LAST = PW'(HISTORY_DEPTH - 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_DEPTH);

	logic [SAMPLE_W-1:0] mem [HISTORY_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [FW-1:0]       fill_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// read walks backwards from the newest word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else if (ctrl.push) begin
			wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			rd_ptr_q <= wr_ptr_q;
			if (fill_q != FILL_MAX) begin
				fill_q <= fill_q + FW'(1);
			end
		end else if (ctrl.rd_en) begin
			rd_ptr_q <= (rd_ptr_q == '0) ? PTR_LAST : rd_ptr_q - PW'(1);
		end
	end

	assign rd_data = rd_data_q;
	assign fill    = fill_q;

endmodule

// File: design/wma_div.sv
// Bit-serial restoring divider: unsigned magnitude by the sample count.
module wma_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wma_pkg::MAG_W-1:0]   dividend,
	input  logic [wma_pkg::WIN_W-1:0]   divisor,
	output logic                        done,
	output logic [wma_pkg::MAG_W-1:0]   quotient
);
	import wma_pkg::*;

	localparam int CW = $clog2(MAG_W + 1);

	logic [MAG_W-1:0] quo_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIN_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[MAG_W-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_W-2:0], fits};
			rem_q <= fits ? WIN_W'(trial - {1'b0, dsr_q}) : trial[WIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
